/* rtl/tmw_pkg.sv */
// ----------------------------------------------------------------------------
// tmw_pkg: text mode terminal writer package
// Screen geometry, control character codes and sequencer states.
// ----------------------------------------------------------------------------
package tmw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Field widths
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ADDR_W  = 11;
  localparam int CELL_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int SWEEP_W = $clog2(CELL_COUNT + 1);
  localparam int TAB_W   = $clog2(TAB_SPACES + 1);

  // Typed constants
  localparam logic [SWEEP_W-1:0] SWEEP_END    = SWEEP_W'(CELL_COUNT);
  localparam logic [SWEEP_W-1:0] SWEEP_LAST   = SWEEP_W'(CELL_COUNT - 1);
  localparam logic [SWEEP_W-1:0] SCROLL_LIMIT = SWEEP_W'(CELL_COUNT - COLUMNS);
  localparam logic [SWEEP_W-1:0] SWEEP_STRIDE = SWEEP_W'(COLUMNS);
  localparam logic [ADDR_W-1:0]  ADDR_COLS    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0]  ADDR_LAST_ROW = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ROW_W-1:0]   ROW_LAST     = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [TAB_W-1:0]   TAB_COUNT    = TAB_W'(TAB_SPACES);
  localparam logic [BYTE_W-1:0]  TEXT_COLOR_RESET = 8'd15;

  // Control character codes
  localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_RD_DATA,
    S_DRAW,
    S_SCROLL,
    S_FILL,
    S_DONE
  } tmw_state_t;

endpackage

/* rtl/text_mode_terminal_writer.sv */
// ----------------------------------------------------------------------------
// text_mode_terminal_writer: 80x25 text screen writer with cursor
// Puts characters at the cursor (with control codes), scrolls, clears the
// screen and reads back single cells.
// ----------------------------------------------------------------------------
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid/in_ready, in_operation, in_char_code,  | in
//          | in_char_color, in_use_own_color, in_cell_index  |
//  result  | out_valid/out_ready, out_cell_value,            | out
//          | out_cursor_row, out_cursor_col                  |
//  config  | cfg_valid/cfg_ready, cfg_text_color             | in
//
//  Sequence: a printable put goes through dispatch, cell write and result
//  load; a read through dispatch, read data and result load; a tab draws
//  TAB_SPACES spaces. A scroll walks the whole screen through the single
//  RAM port pair, and a form feed writes a blank into every cell.
//  Reset: after rst_n the memory is cleared to zero, one cell per cycle,
//  with in_ready low; config writes are taken.
//  Stalls: the block takes one transaction at a time; a finished result
//  waits in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [tmw_pkg::BYTE_W-1:0]    in_char_code,
  input  logic [tmw_pkg::BYTE_W-1:0]    in_char_color,
  input  logic                          in_use_own_color,
  input  logic [tmw_pkg::ADDR_W-1:0]    in_cell_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmw_pkg::CELL_W-1:0]    out_cell_value,
  output logic [tmw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tmw_pkg::COL_W-1:0]     out_cursor_col,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tmw_pkg::BYTE_W-1:0]    cfg_text_color
);

  import tmw_pkg::*;

  // Sequencer and cursor state
  tmw_state_t         state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;      // row_r * COLUMNS + col_r
  logic [SWEEP_W-1:0] sweep_r, sweep_nxt;
  logic [TAB_W-1:0]   tab_r, tab_nxt;

  // Latched transaction
  logic               op_r;
  logic [BYTE_W-1:0]  char_r, char_nxt;
  logic [BYTE_W-1:0]  attr_r;
  logic [ADDR_W-1:0]  idx_r;

  // Scroll write-back stage (data comes from the RAM read port)
  logic               wb_valid_r, wb_valid_nxt;
  logic [ADDR_W-1:0]  wb_dest_r, wb_dest_nxt;
  logic               wb_blank_r, wb_blank_nxt;

  // Read result and output register
  logic [CELL_W-1:0]  read_val_r, read_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  out_cell_r, out_cell_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;

  logic [BYTE_W-1:0]  text_color_r;

  // Shared cursor address adder
  logic [ADDR_W-1:0]  addr_delta;
  logic [ADDR_W-1:0]  addr_sum;
  logic [ADDR_W-1:0]  col_ext;

  // RAM ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  logic [CELL_W-1:0]  blank_cell;
  logic               in_fire;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign blank_cell = {attr_r, CH_SPACE};
  assign col_ext    = {{(ADDR_W - COL_W){1'b0}}, col_r};
  assign addr_sum   = addr_r + addr_delta;

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

  tmw_screen_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      row_r       <= '0;
      col_r       <= '0;
      addr_r      <= '0;
      sweep_r     <= '0;
      tab_r       <= '0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      addr_r      <= addr_nxt;
      sweep_r     <= sweep_nxt;
      tab_r       <= tab_nxt;
      wb_valid_r  <= wb_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_color_r <= cfg_text_color;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_operation;
      attr_r <= in_use_own_color ? in_char_color : text_color_r;
      idx_r  <= in_cell_index;
    end
    char_r     <= char_nxt;
    wb_dest_r  <= wb_dest_nxt;
    wb_blank_r <= wb_blank_nxt;
    read_val_r <= read_val_nxt;
    out_cell_r <= out_cell_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
  end

  // Sequencer: next state, cursor update and RAM control
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    addr_nxt      = addr_r;
    sweep_nxt     = sweep_r;
    tab_nxt       = tab_r;
    char_nxt      = char_r;
    wb_valid_nxt  = 1'b0;
    wb_dest_nxt   = wb_dest_r;
    wb_blank_nxt  = wb_blank_r;
    read_val_nxt  = read_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    addr_delta    = ADDR_W'(1);
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = blank_cell;
    mem_raddr     = idx_r;

    if (in_fire) begin
      char_nxt = in_char_code;
    end

    // Drain the scroll write-back stage
    if (wb_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = wb_dest_r;
      mem_wdata = wb_blank_r ? blank_cell : mem_rdata;
    end

    unique case (state_r)
      S_INIT: begin
        // Zero the screen after reset, one cell per cycle
        mem_we    = 1'b1;
        mem_waddr = sweep_r[ADDR_W-1:0];
        mem_wdata = '0;
        sweep_nxt = sweep_r + SWEEP_W'(1);
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        tab_nxt = '0;
        if (op_r == OP_READ) begin
          // RAM read of idx_r is in flight
          state_nxt = S_RD_DATA;
        end else begin
          unique case (char_r)
            CH_BEL: begin
              state_nxt = S_DONE;
            end
            CH_BS: begin
              if (col_r != '0) begin
                col_nxt    = col_r - COL_W'(1);
                addr_delta = '1;
                addr_nxt   = addr_sum;
              end
              state_nxt = S_DONE;
            end
            CH_TAB: begin
              tab_nxt   = TAB_COUNT;
              char_nxt  = CH_SPACE;
              state_nxt = S_DRAW;
            end
            CH_LF: begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                addr_nxt  = ADDR_LAST_ROW;
                sweep_nxt = '0;
                state_nxt = S_SCROLL;
              end else begin
                row_nxt    = row_r + ROW_W'(1);
                addr_delta = ADDR_COLS - col_ext;
                addr_nxt   = addr_sum;
                state_nxt  = S_DONE;
              end
            end
            CH_FF: begin
              sweep_nxt = '0;
              state_nxt = S_FILL;
            end
            CH_CR: begin
              col_nxt    = '0;
              addr_delta = '0 - col_ext;
              addr_nxt   = addr_sum;
              state_nxt  = S_DONE;
            end
            default: begin
              tab_nxt   = TAB_W'(1);
              state_nxt = S_DRAW;
            end
          endcase
        end
      end

      S_RD_DATA: begin
        read_val_nxt = (idx_r < ADDR_W'(CELL_COUNT)) ? mem_rdata : '0;
        state_nxt    = S_DONE;
      end

      S_DRAW: begin
        // Write the glyph at the cursor and advance
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = {attr_r, char_r};
        tab_nxt   = tab_r - TAB_W'(1);
        if (col_r == COL_LAST) begin
          col_nxt = '0;
          if (row_r == ROW_LAST) begin
            addr_nxt  = ADDR_LAST_ROW;
            sweep_nxt = '0;
            state_nxt = S_SCROLL;
          end else begin
            row_nxt   = row_r + ROW_W'(1);
            addr_nxt  = addr_sum;
            state_nxt = (tab_r == TAB_W'(1)) ? S_DONE : S_DRAW;
          end
        end else begin
          col_nxt   = col_r + COL_W'(1);
          addr_nxt  = addr_sum;
          state_nxt = (tab_r == TAB_W'(1)) ? S_DONE : S_DRAW;
        end
      end

      S_SCROLL: begin
        // Copy each row up one; the bottom row gets blanks
        if (sweep_r != SWEEP_END) begin
          mem_raddr    = ADDR_W'(sweep_r + SWEEP_STRIDE);
          wb_valid_nxt = 1'b1;
          wb_dest_nxt  = sweep_r[ADDR_W-1:0];
          wb_blank_nxt = (sweep_r >= SCROLL_LIMIT);
          sweep_nxt    = sweep_r + SWEEP_W'(1);
        end else begin
          row_nxt   = ROW_LAST;
          col_nxt   = '0;
          addr_nxt  = ADDR_LAST_ROW;
          state_nxt = (tab_r != '0) ? S_DRAW : S_DONE;
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r[ADDR_W-1:0];
        mem_wdata = blank_cell;
        sweep_nxt = sweep_r + SWEEP_W'(1);
        if (sweep_r == SWEEP_LAST) begin
          row_nxt   = '0;
          col_nxt   = '0;
          addr_nxt  = '0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = (op_r == OP_READ) ? read_val_r : '0;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < ROW_W'(ROWS)) && (col_r < COL_W'(COLUMNS)))
    else $error("cursor out of screen range");

  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    int'(addr_r) == int'(row_r) * COLUMNS + int'(col_r))
    else $error("cursor address out of step with row and column");

  a_wb_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> (state_r == S_SCROLL))
    else $error("scroll write-back outside scroll");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL || state_r == S_FILL || state_r == S_INIT) |-> !in_ready)
    else $error("input accepted during screen sweep");
`endif

endmodule

/* rtl/tmw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tmw_screen_ram: screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/text_mode_terminal_writer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_test: self-checking bench for the text screen writer
// Drives character puts and cell reads with random idle gaps and back-pressure.
// A scoreboard keeps its own copy of the screen, cursor and default color, and
// checks every result transaction field by field against it.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_test;
  import tmw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int QUIET_CYCLES = 100;

  // One input transaction and one result transaction
  typedef struct {
    logic              operation;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] char_color;
    logic              use_own;
    logic [ADDR_W-1:0] cell_index;
  } term_cmd_t;

  typedef struct {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } term_result_t;

  // --------------------------------------------------------------------------
  // Screen scoreboard: mirrors the screen and cursor, queues expected results
  // --------------------------------------------------------------------------
  class screen_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] text_color;
    term_result_t      due_q[$];
    int unsigned       errors, checked, puts, reads, scrolls, clears;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row        = '0;
      col        = '0;
      text_color = TEXT_COLOR_RESET;
      errors     = 0;
      checked    = 0;
      puts       = 0;
      reads      = 0;
      scrolls    = 0;
      clears     = 0;
    endfunction

    function void set_color(logic [BYTE_W-1:0] value);
      text_color = value;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void scroll_screen(logic [BYTE_W-1:0] attr);
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = {attr, CH_SPACE};
      row = ROW_LAST;
      scrolls++;
    endfunction

    function void feed_line(logic [BYTE_W-1:0] attr);
      col = '0;
      if (row == ROW_LAST) scroll_screen(attr);
      else row = row + ROW_W'(1);
    endfunction

    function void draw_char(logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] attr);
      cells[int'(row) * COLUMNS + int'(col)] = {attr, code};
      if (col == COL_LAST) feed_line(attr);
      else col = col + COL_W'(1);
    endfunction

    function void blank_screen(logic [BYTE_W-1:0] attr);
      foreach (cells[i]) cells[i] = {attr, CH_SPACE};
      row = '0;
      col = '0;
      clears++;
    endfunction

    // Note one accepted input transaction and queue the result it must cause
    function void note_command(term_cmd_t c);
      term_result_t      r;
      logic [BYTE_W-1:0] attr;
      attr = c.use_own ? c.char_color : text_color;
      r.cell_value = '0;
      if (c.operation == OP_READ) begin
        reads++;
        if (c.cell_index < CELL_COUNT) r.cell_value = cells[c.cell_index];
      end else begin
        puts++;
        case (c.char_code)
          CH_BEL: begin
          end
          CH_BS: begin
            if (col != '0) col = col - COL_W'(1);
          end
          CH_TAB: begin
            repeat (TAB_SPACES) draw_char(CH_SPACE, attr);
          end
          CH_LF: feed_line(attr);
          CH_FF: blank_screen(attr);
          CH_CR: col = '0;
          default: draw_char(c.char_code, attr);
        endcase
      end
      r.cursor_row = row;
      r.cursor_col = col;
      due_q.push_back(r);
    endfunction

    function void flag(string field, logic [CELL_W-1:0] want_v, logic [CELL_W-1:0] got_v);
      errors++;
      $error("result %0d: %s expected 0x%0h, got 0x%0h", checked, field, want_v, got_v);
    endfunction

    // Check one accepted result transaction against the oldest expectation
    function void check_result(term_result_t got);
      term_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        $error("result with nothing expected: cell 0x%0h row %0d col %0d",
               got.cell_value, got.cursor_row, got.cursor_col);
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.cell_value !== want.cell_value)
        flag("cell_value", want.cell_value, got.cell_value);
      if (got.cursor_row !== want.cursor_row)
        flag("cursor_row", CELL_W'(want.cursor_row), CELL_W'(got.cursor_row));
      if (got.cursor_col !== want.cursor_col)
        flag("cursor_col", CELL_W'(want.cursor_col), CELL_W'(got.cursor_col));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic              in_operation     = OP_PUT;
  logic [BYTE_W-1:0] in_char_code     = '0;
  logic [BYTE_W-1:0] in_char_color    = '0;
  logic              in_use_own_color = 1'b0;
  logic [ADDR_W-1:0] in_cell_index    = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [CELL_W-1:0] out_cell_value;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [BYTE_W-1:0] cfg_text_color   = '0;

  screen_scoreboard sb;
  bit               src_idle  = 1'b1;  // sender inserts random gaps
  bit               sink_idle = 1'b1;  // receiver inserts random stalls
  bit               hold_req  = 1'b0;  // receiver holds off for HOLD_CYCLES
  int unsigned      color_writes = 0;
  int unsigned      holds_done   = 0;

  text_mode_terminal_writer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_char_code     (in_char_code),
    .in_char_color    (in_char_color),
    .in_use_own_color (in_use_own_color),
    .in_cell_index    (in_cell_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_value   (out_cell_value),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_col   (out_cursor_col),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_text_color   (cfg_text_color)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Gap length: mostly from the short range, now and then from the long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic term_cmd_t put_cmd(logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] color,
                                        logic own);
    term_cmd_t c;
    c.operation  = OP_PUT;
    c.char_code  = code;
    c.char_color = color;
    c.use_own    = own;
    c.cell_index = ADDR_W'($urandom_range(0, 2047));  // ignored on a put
    return c;
  endfunction

  function automatic term_cmd_t read_cmd(logic [ADDR_W-1:0] cell_addr);
    term_cmd_t c;
    c.operation  = OP_READ;
    c.char_code  = BYTE_W'($urandom_range(0, 255));  // char fields ignored on a read
    c.char_color = BYTE_W'($urandom_range(0, 255));
    c.use_own    = 1'($urandom_range(0, 1));
    c.cell_index = cell_addr;
    return c;
  endfunction

  // Mostly lines of printable text broken by newlines, so the cursor reaches
  // the bottom row and newlines and wraps keep scrolling; the rest is control
  // codes, arbitrary bytes, clears and reads.
  function automatic term_cmd_t random_cmd();
    term_cmd_t   c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c = put_cmd(BYTE_W'($urandom_range(32, 126)), BYTE_W'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0:       c = read_cmd(ADDR_W'(CELL_COUNT + $urandom_range(0, 47)));
        1, 2:    c = read_cmd(ADDR_W'(int'(sb.row) * COLUMNS + $urandom_range(0, COLUMNS - 1)));
        default: c = read_cmd(ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
      endcase
    end else if (pick < 22) c.char_code = CH_LF;
    else if (pick < 26) c.char_code = CH_TAB;
    else if (pick < 29) c.char_code = CH_CR;
    else if (pick < 33) c.char_code = CH_BS;
    else if (pick < 35) c.char_code = CH_BEL;
    else if (pick < 36) c.char_code = CH_FF;
    else if (pick < 44) c.char_code = BYTE_W'($urandom_range(0, 255));
    return c;
  endfunction

  // Drop valid for a random gap, or keep it up for a back-to-back transaction
  task automatic pause_source();
    if (src_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Offer one input transaction and hold it until accepted
  task automatic send_cmd(input term_cmd_t c);
    in_valid         <= 1'b1;
    in_operation     <= c.operation;
    in_char_code     <= c.char_code;
    in_char_color    <= c.char_color;
    in_use_own_color <= c.use_own;
    in_cell_index    <= c.cell_index;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c);
  endtask

  // Wait until every expected result has been taken
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the default color; only called with nothing in flight
  task automatic write_color(input logic [BYTE_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_text_color <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_color(value);
    color_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // hold off long enough for the writer to fill up and stall its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
        out_ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every result transaction; values seen here are the pre-edge ones
  always @(posedge clk) begin : result_monitor
    term_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.cell_value = out_cell_value;
      got.cursor_row = out_cursor_row;
      got.cursor_col = out_cursor_col;
      sb.check_result(got);
    end
  end

  // Bound the run; the limit covers a scroll on every transaction
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
        $display("FAIL text_mode_terminal_writer");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    term_cmd_t         opening[$];
    logic [BYTE_W-1:0] color;
    sb = new();

    // Hold reset, then release; the screen clear after reset stalls input
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with the reset color: reads of the cleared screen and
    // out of range, extreme bytes and colors, each control code, glyphs for
    // unnamed control bytes, backspace at column zero, tab, newline, clear.
    opening.push_back(read_cmd('0));
    opening.push_back(read_cmd('1));
    opening.push_back(read_cmd(ADDR_W'(CELL_COUNT - 1)));
    opening.push_back(put_cmd("A", 8'h00, 1'b1));
    opening.push_back(put_cmd(8'hFF, 8'hFF, 1'b1));
    opening.push_back(put_cmd(8'h00, 8'hFF, 1'b0));
    opening.push_back(put_cmd(8'h01, 8'h3C, 1'b1));
    opening.push_back(put_cmd(CH_BEL, 8'h11, 1'b1));
    opening.push_back(put_cmd(CH_BS, 8'h22, 1'b1));
    opening.push_back(put_cmd(CH_CR, 8'h33, 1'b0));
    opening.push_back(put_cmd(CH_BS, 8'h44, 1'b0));
    opening.push_back(put_cmd(CH_TAB, 8'hA5, 1'b1));
    opening.push_back(read_cmd('0));
    opening.push_back(read_cmd(ADDR_W'(TAB_SPACES)));
    opening.push_back(put_cmd(CH_LF, 8'h66, 1'b1));
    opening.push_back(put_cmd(8'h0B, 8'h77, 1'b1));
    opening.push_back(put_cmd(8'h0E, 8'h88, 1'b0));
    opening.push_back(put_cmd(8'h7F, 8'h99, 1'b1));
    opening.push_back(read_cmd(ADDR_W'(COLUMNS)));
    opening.push_back(put_cmd(CH_FF, 8'h5A, 1'b1));
    opening.push_back(read_cmd(ADDR_W'(CELL_COUNT - 1)));
    opening.push_back(read_cmd('0));
    foreach (opening[i]) begin
      pause_source();
      send_cmd(opening[i]);
    end
    in_valid <= 1'b0;
    drain();

    // Random phases, each under its own default color. Phase 1 holds off the
    // result side while the sender streams; phase 2 runs without any idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        2:       color = 8'h0F;
        default: color = BYTE_W'($urandom_range(0, 255));
      endcase
      write_color(color);
      src_idle  = (p != 1) && (p != 2);
      sink_idle = (p != 2);
      hold_req  = (p == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pause_source();
        send_cmd(random_cmd());
      end
      in_valid <= 1'b0;
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Covered %0d puts and %0d reads (%0d results checked), %0d scrolls,",
             sb.puts, sb.reads, sb.checked, sb.scrolls);
    $display("%0d screen clears, %0d color writes and %0d long result hold-offs.",
             sb.clears, color_writes, holds_done);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS text_mode_terminal_writer");
    end else begin
      $display("FAIL text_mode_terminal_writer");
    end
    $finish;
  end

endmodule
